### rtl/wsfp_pkg.sv
// Shared types and constants for the WebSocket frame parser.
package wsfp_pkg;

    // Parser phase: where in the frame the next stream byte belongs.
    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_LEN16 = 3'd2,
        PH_LEN64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_PING    = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [3:0] OPC_CONT   = 4'd0;
    localparam logic [3:0] OPC_PING   = 4'd9;

    // Result queue depth; one byte can produce two results.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [3:0]  message_opcode;
        logic        message_end;
        logic        run_last;
    } t_result;

    // Results produced by one stream byte, first in order first.
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_emit;

endpackage

### rtl/websocket_frame_parser_top.sv
// Top level of the WebSocket frame parser.
//
// Input channel: one stream byte per request on i_stream_byte, handshake
// i_in_valid / o_in_stall. Output channel: one result per request on o_kind,
// o_payload_byte, o_message_opcode, o_message_end and o_run_last, handshake
// o_out_valid / i_out_stall.
// A byte is captured in an input register, parsed from there once the queue
// has room, and its results sit in a four-entry result queue that drives the
// outputs. The first result of a byte passes the input register and then the
// queue memory before it is visible on the outputs.
// Throughput is one byte per cycle; the parser only advances while the queue
// can take two more results. A ping header that also ends an empty frame
// yields two results, which the queue drains one per cycle unless stalled.
// Reset is synchronous and active low; it returns the parser to the first
// header byte and empties the queue. Nothing needs to be cleared afterwards.
// While the receiver stalls, the head result holds and the queue fills;
// o_in_stall rises once the queue is nearly full and a byte is waiting.
module websocket_frame_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_stream_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload_byte,
    output logic [3:0] o_message_opcode,
    output logic       o_message_end,
    output logic       o_run_last
);
    import wsfp_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       go;
    logic       room;
    t_emit      emit;
    t_result    head;

    assign go         = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_comb begin
        n_in_valid = r_in_valid;
        if (!o_in_stall) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_stream_byte;
        end
    end

    wsfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .o_emit  (emit)
    );

    wsfp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (head)
    );

    assign o_kind           = head.kind;
    assign o_payload_byte   = head.payload_byte;
    assign o_message_opcode = head.message_opcode;
    assign o_message_end    = head.message_end;
    assign o_run_last       = head.run_last;

endmodule

### rtl/wsfp_parser.sv
// Header, length and mask key tracking, payload unmasking; one byte per cycle on i_go.
module wsfp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [7:0]       i_byte,
    output wsfp_pkg::t_emit  o_emit
);
    import wsfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_fin, n_fin;
    logic        r_masked, n_masked;
    logic [3:0]  r_opcode, n_opcode;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_keypos, n_keypos;

    logic        ping_seen;
    logic        end_mark;
    logic        data_out;
    logic        data_end;
    logic [7:0]  data_byte;
    logic [7:0]  key_byte;
    logic [63:0] rem_dec;
    logic        len_done;
    logic        key_done;
    logic        start_payload;
    t_result     ping_res, end_res, data_res;

    always_comb begin
        case (r_keypos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign rem_dec = r_rem - 64'd1;

    // Next state of the parser.
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_fin     = r_fin;
        n_masked  = r_masked;
        n_opcode  = r_opcode;
        n_rem     = r_rem;
        n_key     = r_key;
        n_keypos  = r_keypos;
        ping_seen = 1'b0;
        data_out  = 1'b0;
        data_end  = 1'b0;
        data_byte = 8'd0;
        len_done  = 1'b0;
        key_done  = 1'b0;
        start_payload = 1'b0;
        end_mark  = 1'b0;

        case (r_phase)
            PH_HDR1: begin
                n_masked  = i_byte[7];
                ping_seen = (r_opcode == OPC_PING);
                n_cnt     = 3'd0;
                n_rem     = 64'd0;
                if (i_byte[6:0] == LEN16_CODE) begin
                    n_phase = PH_LEN16;
                end else if (i_byte[6:0] == LEN64_CODE) begin
                    n_phase = PH_LEN64;
                end else begin
                    n_rem    = {57'd0, i_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_LEN16: begin
                n_rem = {48'd0, r_rem[7:0], i_byte};
                if (r_cnt >= 3'd1) begin
                    len_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_LEN64: begin
                n_rem = {r_rem[55:0], i_byte};
                if (r_cnt == 3'd7) begin
                    len_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_byte};
                if (r_cnt >= 3'd3) begin
                    n_cnt    = 3'd0;
                    key_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_DATA: begin
                data_out  = 1'b1;
                data_byte = r_masked ? (i_byte ^ key_byte) : i_byte;
                n_keypos  = r_keypos + 2'd1;
                n_rem     = rem_dec;
                data_end  = r_fin && (rem_dec == 64'd0);
                if (rem_dec == 64'd0) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_fin = i_byte[7];
                if (i_byte[3:0] != OPC_CONT) begin
                    n_opcode = i_byte[3:0];
                end
                n_phase = PH_HDR1;
            end
        endcase

        // Length complete: collect the mask key first when the frame is masked.
        if (len_done) begin
            n_cnt = 3'd0;
            if (n_masked) begin
                n_phase = PH_MASK;
            end else begin
                start_payload = 1'b1;
            end
        end
        if (key_done) begin
            start_payload = 1'b1;
        end
        if (start_payload) begin
            n_keypos = 2'd0;
            if (n_rem == 64'd0) begin
                n_phase  = PH_HDR0;
                end_mark = r_fin;
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    // Result assembly; the ping notice always comes before an end marker.
    always_comb begin
        ping_res = '{kind: KIND_PING, payload_byte: 8'd0, message_opcode: r_opcode,
                     message_end: 1'b0, run_last: !end_mark};
        end_res  = '{kind: KIND_END, payload_byte: 8'd0, message_opcode: r_opcode,
                     message_end: 1'b1, run_last: 1'b1};
        data_res = '{kind: KIND_PAYLOAD, payload_byte: data_byte, message_opcode: r_opcode,
                     message_end: data_end, run_last: 1'b1};
        o_emit = '0;
        if (i_go) begin
            if (data_out) begin
                o_emit.num   = 2'd1;
                o_emit.first = data_res;
            end else if (ping_seen) begin
                o_emit.num    = end_mark ? 2'd2 : 2'd1;
                o_emit.first  = ping_res;
                o_emit.second = end_res;
            end else if (end_mark) begin
                o_emit.num   = 2'd1;
                o_emit.first = end_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_cnt    <= 3'd0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_opcode <= 4'd0;
            r_rem    <= 64'd0;
            r_key    <= 32'd0;
            r_keypos <= 2'd0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_opcode <= n_opcode;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_keypos <= n_keypos;
        end
    end

    // The payload phase is only ever entered with bytes left to deliver.
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_rem != 64'd0))
        else $error("payload phase with zero remaining length");

    // Two results only come from a ping header that also closes an empty frame.
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.num == 2'd2) |-> (r_phase == PH_HDR1 && r_opcode == OPC_PING))
        else $error("two results outside a ping header");

endmodule

### rtl/wsfp_outq.sv
// Small result queue taking up to two results per cycle and delivering one unless i_stall holds it.
module wsfp_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wsfp_pkg::t_emit    i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output wsfp_pkg::t_result  o_data
);
    import wsfp_pkg::*;

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_head, n_head;
    logic [QAW-1:0]   r_tail, n_tail;
    logic [QCW-1:0]   r_count, n_count;
    logic             pop;
    logic [QAW-1:0]   tail_next;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_head];
    assign pop       = o_valid && !i_stall;
    // Room for a worst-case request, judged on the registered fill level.
    assign o_room    = (r_count <= QCW'(QDEPTH - 2));
    assign tail_next = r_tail + QAW'(1);

    always_comb begin
        n_head  = pop ? r_head + QAW'(1) : r_head;
        n_tail  = r_tail + QAW'(i_push.num);
        n_count = r_count + QCW'(i_push.num) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[tail_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

endmodule

### tb/websocket_frame_parser_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the WebSocket frame parser top level.
module websocket_frame_parser_top_test;
    import wsfp_pkg::*;

    localparam logic [3:0] OPC_TEXT      = 4'h1;
    localparam logic [3:0] OPC_BINARY    = 4'h2;
    localparam logic [3:0] OPC_CLOSE     = 4'h8;
    localparam logic [3:0] OPC_PONG      = 4'hA;
    localparam logic [3:0] OPC_RSVD_CTRL = 4'hF;

    localparam int RANDOM_BYTES     = 850;
    localparam int NO_IDLE_BYTES    = 120;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 6;

    typedef enum int {
        LEN_SHORT,
        LEN_WORD,
        LEN_LONG
    } t_len_form;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_stream_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_payload_byte;
    logic [3:0] o_message_opcode;
    logic       o_message_end;
    logic       o_run_last;

    websocket_frame_parser_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_stream_byte    (i_stream_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_message_opcode (o_message_opcode),
        .o_message_end    (o_message_end),
        .o_run_last       (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // Parser state as the predictor tracks it.
    t_phase      frame_phase = PH_HDR0;
    logic [2:0]  hdr_count = '0;
    logic        frame_fin = 1'b0;
    logic        frame_masked = 1'b0;
    logic [3:0]  cur_opcode = OPC_CONT;
    logic [63:0] bytes_left = '0;
    logic [31:0] mask_word = '0;
    logic [1:0]  key_index = '0;
    int          byte_results;

    t_result due_results[$];
    int      fail_count = 0;
    int      bytes_sent = 0;
    bit      tx_gaps = 1'b1;
    logic    rx_gaps = 1'b1;
    logic    long_hold_req = 1'b0;

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) return int'($urandom_range(1, 3));
        if (r < 95) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    task automatic queue_result(input t_kind kind, input logic [7:0] data, input logic msg_end);
        t_result r;
        r.kind           = kind;
        r.payload_byte   = data;
        r.message_opcode = cur_opcode;
        r.message_end    = msg_end;
        r.run_last       = 1'b0;
        due_results.push_back(r);
        byte_results++;
    endtask

    task automatic payload_start();
        key_index = '0;
        if (bytes_left == 64'd0) begin
            frame_phase = PH_HDR0;
            if (frame_fin) queue_result(KIND_END, 8'h00, 1'b1);
        end else begin
            frame_phase = PH_DATA;
        end
    endtask

    task automatic length_done();
        hdr_count = '0;
        if (frame_masked) frame_phase = PH_MASK;
        else payload_start();
    endtask

    // Advances the tracked parser by one stream byte and queues what it produces.
    task automatic parse_stream_byte(input logic [7:0] b);
        t_result    r;
        logic [7:0] plain;
        byte_results = 0;
        case (frame_phase)
            PH_HDR1: begin
                frame_masked = b[7];
                if (cur_opcode == OPC_PING) queue_result(KIND_PING, 8'h00, 1'b0);
                hdr_count  = '0;
                bytes_left = '0;
                if (b[6:0] == LEN16_CODE) begin
                    frame_phase = PH_LEN16;
                end else if (b[6:0] == LEN64_CODE) begin
                    frame_phase = PH_LEN64;
                end else begin
                    bytes_left = {57'd0, b[6:0]};
                    length_done();
                end
            end
            PH_LEN16: begin
                bytes_left = {48'd0, bytes_left[7:0], b};
                if (hdr_count >= 3'd1) length_done();
                else hdr_count++;
            end
            PH_LEN64: begin
                bytes_left = {bytes_left[55:0], b};
                if (hdr_count == 3'd7) length_done();
                else hdr_count++;
            end
            PH_MASK: begin
                mask_word = {mask_word[23:0], b};
                if (hdr_count == 3'd3) begin
                    hdr_count = '0;
                    payload_start();
                end else begin
                    hdr_count++;
                end
            end
            PH_DATA: begin
                plain = b;
                // The first key byte received sits in the top of the key word.
                if (frame_masked) plain = b ^ mask_word[8 * (3 - int'(key_index)) +: 8];
                key_index++;
                bytes_left--;
                queue_result(KIND_PAYLOAD, plain, frame_fin && bytes_left == 64'd0);
                if (bytes_left == 64'd0) frame_phase = PH_HDR0;
            end
            default: begin
                frame_fin = b[7];
                if (b[3:0] != OPC_CONT) cur_opcode = b[3:0];
                frame_phase = PH_HDR1;
            end
        endcase
        if (byte_results > 0) begin
            r = due_results.pop_back();
            r.run_last = 1'b1;
            due_results.push_back(r);
        end
    endtask

    // Offers one stream byte and returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (tx_gaps && $urandom_range(99) < 25) ? idle_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_stream_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] first_hdr(input logic fin, input logic [2:0] rsv,
                                             input logic [3:0] opc);
        return {fin, rsv, opc};
    endfunction

    function automatic logic [7:0] second_hdr(input logic masked, input logic [6:0] len7);
        return {masked, len7};
    endfunction

    function automatic logic [7:0] payload_value();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_frame(input logic [7:0] hdr0, input logic masked, input t_len_form form,
                              input logic [63:0] len, input logic [31:0] key,
                              input int payload_count);
        send_byte(hdr0);
        case (form)
            LEN_SHORT: send_byte(second_hdr(masked, len[6:0]));
            LEN_WORD: begin
                send_byte(second_hdr(masked, LEN16_CODE));
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte(second_hdr(masked, LEN64_CODE));
                for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        end
        for (int i = 0; i < payload_count; i++) send_byte(payload_value());
    endtask

    // Well-formed random frames; noisy ones may add reserved bits and any opcode.
    task automatic send_random_frame(input bit noisy);
        logic [3:0] opc;
        logic       fin;
        logic [2:0] rsv;
        logic       masked;
        t_len_form  form;
        int         len;
        int         pick;
        pick = $urandom_range(99);
        if (noisy || pick >= 85) opc = 4'($urandom_range(15));
        else if (pick < 30) opc = OPC_CONT;
        else if (pick < 50) opc = OPC_TEXT;
        else if (pick < 62) opc = OPC_BINARY;
        else if (pick < 74) opc = OPC_PING;
        else if (pick < 80) opc = OPC_PONG;
        else opc = OPC_CLOSE;
        fin    = ($urandom_range(99) < 60);
        rsv    = noisy ? 3'($urandom_range(7)) : 3'b000;
        masked = 1'($urandom_range(1));
        form   = LEN_SHORT;
        pick   = $urandom_range(99);
        if (pick < 25) begin
            len = 0;
        end else if (pick < 75) begin
            len = $urandom_range(1, 8);
        end else if (pick < 88) begin
            len = $urandom_range(9, 40);
        end else begin
            form = (pick < 94) ? LEN_WORD : LEN_LONG;
            len  = ($urandom_range(9) == 0) ? $urandom_range(256, 300) : $urandom_range(60);
        end
        send_frame(first_hdr(fin, rsv, opc), masked, form, 64'(len), $urandom(), len);
    endtask

    task automatic test_directed_frames();
        // Unmasked text frame carrying both byte extremes.
        send_byte(first_hdr(1'b1, 3'b000, OPC_TEXT));
        send_byte(second_hdr(1'b0, 7'd2));
        send_byte(8'h00);
        send_byte(8'hFF);
        // Masked binary fragment, then an empty final continuation that keeps binary.
        send_byte(first_hdr(1'b0, 3'b000, OPC_BINARY));
        send_byte(second_hdr(1'b1, 7'd1));
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_byte(first_hdr(1'b1, 3'b000, OPC_CONT));
        send_byte(second_hdr(1'b0, 7'd0));
        // Empty ping: the notice and the end marker come from the same byte.
        send_byte(first_hdr(1'b1, 3'b000, OPC_PING));
        send_byte(second_hdr(1'b0, 7'd0));
        // Empty frame without fin produces nothing.
        send_byte(first_hdr(1'b0, 3'b000, OPC_TEXT));
        send_byte(second_hdr(1'b0, 7'd0));
        // Reserved bits and a reserved opcode with a 16-bit length of one.
        send_byte(first_hdr(1'b1, 3'b111, OPC_RSVD_CTRL));
        send_byte(second_hdr(1'b0, LEN16_CODE));
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h7F);
        // Masked empty frame: the end marker comes with the last key byte.
        send_byte(first_hdr(1'b1, 3'b000, OPC_TEXT));
        send_byte(second_hdr(1'b1, LEN16_CODE));
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);
    endtask

    task automatic test_random_frames();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) send_random_frame($urandom_range(99) < 20);
    endtask

    // The receiver holds off while the sender keeps offering, so the result queue fills.
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        long_hold_req <= 1'b1;
        @(posedge i_clk);
        long_hold_req <= 1'b0;
        send_frame(first_hdr(1'b1, 3'b000, OPC_TEXT), 1'b0, LEN_SHORT, 64'd80, 32'h0, 80);
        wait_drained();
        tx_gaps = 1'b1;
    endtask

    task automatic test_no_idle();
        int start;
        tx_gaps = 1'b0;
        rx_gaps <= 1'b0;
        start = bytes_sent;
        while (bytes_sent - start < NO_IDLE_BYTES) send_random_frame(1'b0);
        tx_gaps = 1'b1;
        rx_gaps <= 1'b1;
    endtask

    // A 64-bit length with the top bit set never ends, so this runs last.
    task automatic test_unbounded_length();
        send_frame(first_hdr(1'b1, 3'b000, OPC_BINARY), 1'b1, LEN_LONG,
                   64'h8000_0000_0000_0005, $urandom(), 40);
    endtask

    // Receiver: random stall bursts, none if rx_gaps is low, or a requested long hold.
    int   hold_left = 0;
    int   burst_left = 0;
    logic burst_stall = 1'b0;

    always @(posedge i_clk) begin
        if (long_hold_req) hold_left = LONG_HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!rx_gaps) begin
            i_out_stall <= 1'b0;
        end else begin
            if (burst_left == 0) begin
                burst_stall = ($urandom_range(99) < 30);
                burst_left  = burst_stall ? idle_length() : int'($urandom_range(1, 12));
            end
            burst_left--;
            i_out_stall <= burst_stall;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: kind %0d byte %02h opcode %0d end %0b last %0b",
                             o_kind, o_payload_byte, o_message_opcode, o_message_end,
                             o_run_last);
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind || o_payload_byte !== want.payload_byte ||
                    o_message_opcode !== want.message_opcode ||
                    o_message_end !== want.message_end || o_run_last !== want.run_last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result mismatch: expected kind %0d byte %02h opcode %0d end %0b last %0b",
                                 want.kind, want.payload_byte, want.message_opcode,
                                 want.message_end, want.run_last);
                        $display("                 got kind %0d byte %02h opcode %0d end %0b last %0b",
                                 o_kind, o_payload_byte, o_message_opcode, o_message_end,
                                 o_run_last);
                    end
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : run_tests
        int settle;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        wait_drained();
        test_random_frames();
        wait_drained();
        test_backpressure();
        test_no_idle();
        wait_drained();
        test_unbounded_length();
        i_in_valid <= 1'b0;
        settle = 0;
        while (due_results.size() != 0 && settle < 20000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0)
            $display("%0d expected results never arrived", due_results.size());
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
